// File: hw/rtl/oep_pkg.sv
package oep_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_CHECK,
    ST_HRD,
    ST_HCHK,
    ST_TRD,
    ST_TCHK,
    ST_SWAP_H,
    ST_SWAP_T,
    ST_EMIT_RD,
    ST_EMIT
  } oep_state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_wr;
    logic init_ptrs;
    logic rd_head;
    logic rd_tail;
    logic rd_emit;
    logic head_inc;
    logic tail_dec;
    logic cap_h;
    logic cap_t;
    logic wr_h;
    logic wr_t;
    logic emit_inc;
    logic clr_count;
  } oep_cmd_t;

  // Status from the datapath back to the sequencer
  typedef struct packed {
    logic in_done;
    logic rd_odd;
    logic head_lt_n;
    logic tail_gt0;
    logic tail_gt_head;
    logic emit_last;
  } oep_sts_t;

endpackage

// File: hw/rtl/oep_ctrl.sv
module oep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  oep_pkg::oep_sts_t sts,
  output oep_pkg::oep_cmd_t cmd
);
  import oep_pkg::*;

  oep_state_t state_r;
  oep_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (sts.in_done) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init_ptrs = 1'b1;
        state_nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.tail_gt_head) begin
          state_nxt = ST_HRD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      // head scan: advance past odd words
      ST_HRD: begin
        if (sts.head_lt_n) begin
          cmd.rd_head = 1'b1;
          state_nxt   = ST_HCHK;
        end else begin
          state_nxt = ST_TRD;
        end
      end
      ST_HCHK: begin
        if (sts.rd_odd) begin
          cmd.head_inc = 1'b1;
          state_nxt    = ST_HRD;
        end else begin
          cmd.cap_h = 1'b1;
          state_nxt = ST_TRD;
        end
      end
      // tail scan: step back past even words
      ST_TRD: begin
        if (sts.tail_gt0) begin
          cmd.rd_tail = 1'b1;
          state_nxt   = ST_TCHK;
        end else begin
          state_nxt = ST_SWAP_H;
        end
      end
      ST_TCHK: begin
        if (!sts.rd_odd) begin
          cmd.tail_dec = 1'b1;
          state_nxt    = ST_TRD;
        end else begin
          cmd.cap_t = 1'b1;
          state_nxt = ST_SWAP_H;
        end
      end
      ST_SWAP_H: begin
        if (sts.tail_gt_head) begin
          cmd.wr_h  = 1'b1;
          state_nxt = ST_SWAP_T;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_SWAP_T: begin
        cmd.wr_t  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.clr_count = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            cmd.emit_inc = 1'b1;
            state_nxt    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// File: hw/rtl/oep_dpath.sv
module oep_dpath #(
  parameter int MAX_WORDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  oep_pkg::oep_cmd_t  cmd,
  output oep_pkg::oep_sts_t  sts,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic signed [31:0] out_value_res,
  output logic               out_last_res
);
  import oep_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW:0]   ONE_W  = (CW + 1)'(1);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_WORDS - 1);
  localparam logic [CW-1:0] FULL_C = CW'(MAX_WORDS);

  logic [31:0]   mem [MAX_WORDS];
  logic [31:0]   rdata_r;
  logic [31:0]   hword_r;
  logic [31:0]   tword_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] head_r;
  logic [CW-1:0] head_nxt;
  logic [CW-1:0] tp1_r;      // tail pointer plus one, so an empty tail reads as zero
  logic [CW-1:0] tp1_nxt;
  logic [CW-1:0] k_r;
  logic [CW-1:0] k_nxt;
  logic [CW-1:0] tail_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic          wr_en;

  assign tail_idx = tp1_r - ONE_C;

  always_comb begin
    if (cmd.rd_head) begin
      rd_addr = head_r[AW-1:0];
    end else if (cmd.rd_tail) begin
      rd_addr = tail_idx[AW-1:0];
    end else begin
      rd_addr = k_r[AW-1:0];
    end
  end

  always_comb begin
    if (cmd.load_wr) begin
      wr_addr = count_r[AW-1:0];
      wr_data = $unsigned(in_value);
    end else if (cmd.wr_h) begin
      wr_addr = head_r[AW-1:0];
      wr_data = tword_r;
    end else begin
      wr_addr = tail_idx[AW-1:0];
      wr_data = hword_r;
    end
  end

  assign rd_en = cmd.rd_head | cmd.rd_tail | cmd.rd_emit;
  assign wr_en = cmd.load_wr | cmd.wr_h | cmd.wr_t;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.cap_h) begin
      hword_r <= rdata_r;
    end
    if (cmd.cap_t) begin
      tword_r <= rdata_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.load_wr) begin
      count_nxt = count_r + ONE_C;
    end
    head_nxt = head_r;
    if (cmd.init_ptrs) begin
      head_nxt = '0;
    end else if (cmd.head_inc) begin
      head_nxt = head_r + ONE_C;
    end
    tp1_nxt = tp1_r;
    if (cmd.init_ptrs) begin
      tp1_nxt = count_r;
    end else if (cmd.tail_dec) begin
      tp1_nxt = tail_idx;
    end
    k_nxt = k_r;
    if (cmd.init_ptrs || cmd.clr_count) begin
      k_nxt = '0;
    end else if (cmd.emit_inc) begin
      k_nxt = k_r + ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tp1_r   <= '0;
      k_r     <= '0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tp1_r   <= tp1_nxt;
      k_r     <= k_nxt;
    end
  end

  // a full block closes as if the word were marked last
  assign sts.in_done      = in_last | (count_r == LAST_C);
  assign sts.rd_odd       = rdata_r[0];
  assign sts.head_lt_n    = head_r < count_r;
  assign sts.tail_gt0     = tp1_r != '0;
  assign sts.tail_gt_head = {1'b0, tp1_r} > ({1'b0, head_r} + ONE_W);
  assign sts.emit_last    = (k_r + ONE_C) == count_r;

  assign out_value_res = $signed(rdata_r);
  assign out_last_res  = sts.emit_last;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_C)
    else $error("word count past block size");
  a_head_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_head |-> sts.head_lt_n)
    else $error("head read beyond block");
  a_tail_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_tail |-> sts.tail_gt0)
    else $error("tail read below block");
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_h |=> (cmd.wr_t && $stable(head_r) && $stable(tp1_r)))
    else $error("swap halves split or pointers moved");
`endif

endmodule

// File: hw/rtl/odd_even_partition_unit.sv
// Odd/even partition unit.
// Input channel (in_valid/in_ready, in_value, in_last): one signed 32-bit word
// per handshake. Words are stored until a word marked last arrives, or until
// MAX_WORDS words are held, which closes the block the same way.
// The block is then reordered in place, odd words first, with a two-pointer
// pass: the head scans up past odd words, the tail scans down past even words,
// and the pair is swapped while head is below tail.
// Output channel (out_valid/out_ready, out_value_res, out_last_res): one word
// per handshake, the whole block in order, out_last_res high on its final word.
// Loading writes each accepted word straight into the word memory. Each scan
// step of the pass is a memory read, then a test of bit 0; each swap writes the
// head word, then the tail word; each readout word is read, then presented. The
// word memory has one read port and one write port, and its reads are registered.
// in_ready is high only while loading; no word is taken during the pass or
// the readout. A stalled receiver simply holds the current output word.
// Reset clears the sequencer and the counters; the word memory is not cleared.
module odd_even_partition_unit #(
  parameter int MAX_WORDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value_res,
  output logic               out_last_res
);
  import oep_pkg::*;

  oep_cmd_t cmd;
  oep_sts_t sts;

  oep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oep_dpath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res)
  );

endmodule
